// ===== rtl/slcp_pkg.sv =====
// Shared types, command codes and helper functions of the sound-log command parser.
package slcp_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOOP_OFFSET   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_STREAM_ORIGIN = 1'd1;

  localparam logic [31:0] LOOP_BASE          = 32'h0000_001C;
  localparam logic [31:0] STREAM_ORIGIN_INIT = 32'd64;

  // Command bytes
  localparam logic [7:0] CMD_IGNORE1    = 8'h31;
  localparam logic [7:0] CMD_PSG_ALT    = 8'h4F;
  localparam logic [7:0] CMD_PSG        = 8'h50;
  localparam logic [7:0] CMD_IGNORE2A   = 8'h52;
  localparam logic [7:0] CMD_IGNORE2B   = 8'h53;
  localparam logic [7:0] CMD_FM_A       = 8'h54;
  localparam logic [7:0] CMD_FM_B       = 8'h55;
  localparam logic [7:0] CMD_WAIT_WORD  = 8'h61;
  localparam logic [7:0] CMD_WAIT_NTSC  = 8'h62;
  localparam logic [7:0] CMD_WAIT_PAL   = 8'h63;
  localparam logic [7:0] CMD_END        = 8'h66;
  localparam logic [7:0] CMD_DATA_BLOCK = 8'h67;
  localparam logic [7:0] CMD_IGNORE2C   = 8'hB8;
  localparam logic [7:0] CMD_IGNORE4    = 8'hE0;
  localparam logic [3:0] CMD_WAIT_SHORT_HI = 4'h7;
  localparam logic [3:0] CMD_WAIT_NIB_HI   = 4'h8;

  localparam logic [15:0] WAIT_NTSC = 16'd735;
  localparam logic [15:0] WAIT_PAL  = 16'd882;

  // Result kinds
  localparam logic [2:0] EV_PSG  = 3'd0;
  localparam logic [2:0] EV_FM_A = 3'd1;
  localparam logic [2:0] EV_FM_B = 3'd2;
  localparam logic [2:0] EV_WAIT = 3'd3;
  localparam logic [2:0] EV_SEEK = 3'd4;

  typedef enum logic [1:0] {
    PH_COMMAND,
    PH_OPERAND,
    PH_SKIP
  } phase_t;

  typedef enum logic [2:0] {
    OP_PSG,
    OP_FM_A,
    OP_FM_B,
    OP_WAIT,
    OP_SEEK_LOOP,
    OP_SEEK_START
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  chip_reg;
    logic [7:0]  chip_val;
    logic [15:0] wait_len;
  } ev_t;

  function automatic logic [2:0] operand_count(input logic [7:0] cmd);
    logic [2:0] n;
    case (cmd)
      CMD_IGNORE1, CMD_PSG_ALT, CMD_PSG: n = 3'd1;
      CMD_IGNORE2A, CMD_IGNORE2B, CMD_FM_A, CMD_FM_B, CMD_WAIT_WORD, CMD_IGNORE2C: n = 3'd2;
      CMD_IGNORE4: n = 3'd4;
      CMD_DATA_BLOCK: n = 3'd6;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== rtl/slcp_front.sv =====
// Byte decoder: tracks command, operand and skip phases and classifies finished commands.
module slcp_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [7:0]       stream_byte,
  output logic             ev_valid,
  output slcp_pkg::ev_t    ev
);

  slcp_pkg::phase_t phase, phase_next;
  logic [7:0]  current_command, current_command_next;
  logic [2:0]  byte_index, byte_index_next;
  logic [31:0] assembled_word, assembled_word_next;
  logic [31:0] skip_remaining, skip_remaining_next;

  logic [2:0]  n_cur;
  logic [2:0]  n_new;
  logic [7:0]  first;
  logic [31:0] block_size;
  logic        last_operand;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= slcp_pkg::PH_COMMAND;
      current_command <= '0;
      byte_index      <= '0;
      assembled_word  <= '0;
      skip_remaining  <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      current_command <= current_command_next;
      byte_index      <= byte_index_next;
      assembled_word  <= assembled_word_next;
      skip_remaining  <= skip_remaining_next;
    end
  end

  always_comb begin
    n_cur        = slcp_pkg::operand_count(current_command);
    n_new        = slcp_pkg::operand_count(stream_byte);
    first        = assembled_word[31:24];
    block_size   = {stream_byte, assembled_word[31:8]};
    last_operand = ({1'b0, byte_index} + 4'd1) >= {1'b0, n_cur};

    phase_next           = phase;
    current_command_next = current_command;
    byte_index_next      = byte_index;
    assembled_word_next  = assembled_word;
    skip_remaining_next  = skip_remaining;

    ev_valid    = 1'b0;
    ev.op       = slcp_pkg::OP_WAIT;
    ev.chip_reg = '0;
    ev.chip_val = '0;
    ev.wait_len = '0;

    case (phase)
      slcp_pkg::PH_SKIP: begin
        skip_remaining_next = skip_remaining - 32'd1;
        if (skip_remaining == 32'd1) phase_next = slcp_pkg::PH_COMMAND;
      end
      slcp_pkg::PH_OPERAND: begin
        if (last_operand) begin
          phase_next      = slcp_pkg::PH_COMMAND;
          byte_index_next = '0;
          case (current_command)
            slcp_pkg::CMD_PSG_ALT, slcp_pkg::CMD_PSG: begin
              ev_valid    = 1'b1;
              ev.op       = slcp_pkg::OP_PSG;
              ev.chip_val = stream_byte;
            end
            slcp_pkg::CMD_FM_A: begin
              ev_valid    = 1'b1;
              ev.op       = slcp_pkg::OP_FM_A;
              ev.chip_reg = first;
              ev.chip_val = stream_byte;
            end
            slcp_pkg::CMD_FM_B: begin
              ev_valid    = 1'b1;
              ev.op       = slcp_pkg::OP_FM_B;
              ev.chip_reg = first;
              ev.chip_val = stream_byte;
            end
            slcp_pkg::CMD_WAIT_WORD: begin
              ev_valid    = 1'b1;
              ev.op       = slcp_pkg::OP_WAIT;
              ev.wait_len = {stream_byte, first};
            end
            slcp_pkg::CMD_DATA_BLOCK: begin
              // An empty block goes straight back to command decoding
              if (block_size != 32'd0) begin
                skip_remaining_next = block_size;
                phase_next          = slcp_pkg::PH_SKIP;
              end
            end
            default: ;
          endcase
        end else begin
          assembled_word_next = {stream_byte, assembled_word[31:8]};
          byte_index_next     = byte_index + 3'd1;
        end
      end
      default: begin
        if (n_new != 3'd0) begin
          current_command_next = stream_byte;
          byte_index_next      = '0;
          assembled_word_next  = '0;
          phase_next           = slcp_pkg::PH_OPERAND;
        end else begin
          ev_valid = 1'b1;
          if (stream_byte == slcp_pkg::CMD_WAIT_NTSC) begin
            ev.op       = slcp_pkg::OP_WAIT;
            ev.wait_len = slcp_pkg::WAIT_NTSC;
          end else if (stream_byte == slcp_pkg::CMD_WAIT_PAL) begin
            ev.op       = slcp_pkg::OP_WAIT;
            ev.wait_len = slcp_pkg::WAIT_PAL;
          end else if (stream_byte[7:4] == slcp_pkg::CMD_WAIT_SHORT_HI) begin
            ev.op       = slcp_pkg::OP_WAIT;
            ev.wait_len = {12'd0, stream_byte[3:0]} + 16'd1;
          end else if (stream_byte[7:4] == slcp_pkg::CMD_WAIT_NIB_HI) begin
            ev.op       = slcp_pkg::OP_WAIT;
            ev.wait_len = {12'd0, stream_byte[3:0]};
          end else if (stream_byte == slcp_pkg::CMD_END) begin
            ev.op = slcp_pkg::OP_SEEK_LOOP;
          end else begin
            ev.op = slcp_pkg::OP_SEEK_START;
          end
        end
      end
    endcase
  end

endmodule

// ===== rtl/slcp_queue.sv =====
// Short flop queue of classified commands between decoder and event generator.
module slcp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  slcp_pkg::ev_t push_ev,
  output logic          full,
  output logic          pop_valid,
  input  logic          pop,
  output slcp_pkg::ev_t pop_ev
);

  slcp_pkg::ev_t entries [slcp_pkg::QUEUE_DEPTH];
  logic [slcp_pkg::QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [slcp_pkg::QUEUE_CNT_W-1:0] count;
  logic do_push, do_pop;

  assign full      = count == slcp_pkg::QUEUE_CNT_W'(slcp_pkg::QUEUE_DEPTH);
  assign pop_valid = count != '0;
  assign pop_ev    = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_ev;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/slcp_back.sv =====
// Event generator: turns queued commands into result items and keeps the sample total.
module slcp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          ev_valid,
  input  slcp_pkg::ev_t ev,
  output logic          ev_pop,
  input  logic [31:0]   loop_offset,
  input  logic [31:0]   stream_origin,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    event_kind,
  output logic [7:0]    chip_register,
  output logic [7:0]    chip_value,
  output logic [15:0]   wait_samples,
  output logic [31:0]   seek_position,
  output logic [31:0]   total_samples
);

  logic [31:0] sample_total, sample_total_next;
  logic [2:0]  kind_next;
  logic [31:0] seek_next;
  logic [15:0] wait_next;

  assign ev_pop = ev_valid && (!out_valid || out_ready);

  always_comb begin
    sample_total_next = sample_total;
    kind_next         = slcp_pkg::EV_SEEK;
    seek_next         = '0;
    wait_next         = '0;
    case (ev.op)
      slcp_pkg::OP_PSG:  kind_next = slcp_pkg::EV_PSG;
      slcp_pkg::OP_FM_A: kind_next = slcp_pkg::EV_FM_A;
      slcp_pkg::OP_FM_B: kind_next = slcp_pkg::EV_FM_B;
      slcp_pkg::OP_WAIT: begin
        kind_next         = slcp_pkg::EV_WAIT;
        wait_next         = ev.wait_len;
        sample_total_next = sample_total + {16'd0, ev.wait_len};
      end
      slcp_pkg::OP_SEEK_LOOP: begin
        seek_next = (loop_offset == 32'd0) ? stream_origin
                                           : slcp_pkg::LOOP_BASE + loop_offset;
      end
      default: seek_next = stream_origin;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      sample_total <= '0;
    end else if (ev_pop) begin
      out_valid    <= 1'b1;
      sample_total <= sample_total_next;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload of the output register
  always_ff @(posedge clk) begin
    if (ev_pop) begin
      event_kind    <= kind_next;
      chip_register <= ev.chip_reg;
      chip_value    <= ev.chip_val;
      wait_samples  <= wait_next;
      seek_position <= seek_next;
      total_samples <= sample_total_next;
    end
  end

endmodule

// ===== rtl/sound_log_command_parser.sv =====
// Top level of the sound-log command parser: config registers, decoder, queue, event generator.
//
// Takes one stream byte per cycle and answers with at most one event item per
// byte: a chip register write, a wait with the running sample total, or a seek
// the byte source must follow (bytes after a seek are taken as coming from the
// new position). A byte is decoded in the cycle it is accepted and its event is
// written into a four-entry queue at the accepting edge; from there it moves
// into the output register, which offers it, once that register is free.
// Sustained rate is one byte per clock; the input stalls only when the queue is
// full, i.e. when the event consumer holds off while four events wait in the
// queue behind the held output item.
// Write loop_offset and stream_origin only while no item is in flight.
module sound_log_command_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] stream_byte
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [95:0]                     m_tdata,   // [7:0] chip_register, [15:8] chip_value,
                                                     // [31:16] wait_samples,
                                                     // [63:32] seek_position,
                                                     // [95:64] total_samples
  output logic [2:0]                      m_tuser,   // [2:0] event_kind
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [slcp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]                     cfg_data
);

  logic [31:0]   loop_offset;
  logic [31:0]   stream_origin;
  logic          q_full;
  logic          front_valid;
  slcp_pkg::ev_t front_ev;
  logic          q_valid;
  slcp_pkg::ev_t q_ev;
  logic          q_pop;
  logic          accept;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      loop_offset   <= '0;
      stream_origin <= slcp_pkg::STREAM_ORIGIN_INIT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        slcp_pkg::CFG_LOOP_OFFSET:   loop_offset   <= cfg_data;
        slcp_pkg::CFG_STREAM_ORIGIN: stream_origin <= cfg_data;
        default: ;
      endcase
    end
  end

  slcp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .stream_byte (s_tdata),
    .ev_valid    (front_valid),
    .ev          (front_ev)
  );

  slcp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && front_valid),
    .push_ev   (front_ev),
    .full      (q_full),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_ev    (q_ev)
  );

  slcp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .ev_valid      (q_valid),
    .ev            (q_ev),
    .ev_pop        (q_pop),
    .loop_offset   (loop_offset),
    .stream_origin (stream_origin),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .event_kind    (m_tuser),
    .chip_register (m_tdata[7:0]),
    .chip_value    (m_tdata[15:8]),
    .wait_samples  (m_tdata[31:16]),
    .seek_position (m_tdata[63:32]),
    .total_samples (m_tdata[95:64])
  );

endmodule

// ===== rtl/slcp_checker.sv =====
// Port-level checker for the sound-log command parser, bound to the top level.
module slcp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata,
  input logic [2:0]  m_tuser
);

  logic [31:0] last_total;
  logic        out_accept;

  assign out_accept = m_tvalid && m_tready;

  // Track the total carried by the last delivered item
  always_ff @(posedge clk) begin
    if (rst) begin
      last_total <= '0;
    end else if (out_accept) begin
      last_total <= m_tdata[95:64];
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output item changed while stalled");

  a_total_wait: assert property (@(posedge clk) disable iff (rst)
    out_accept && m_tuser == slcp_pkg::EV_WAIT |->
      m_tdata[95:64] == last_total + {16'd0, m_tdata[31:16]})
    else $error("wait did not advance the sample total by its length");

  a_total_hold: assert property (@(posedge clk) disable iff (rst)
    out_accept && m_tuser != slcp_pkg::EV_WAIT |-> m_tdata[95:64] == last_total)
    else $error("non-wait item changed the sample total");

  a_write_fields: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == slcp_pkg::EV_PSG || m_tuser == slcp_pkg::EV_FM_A ||
                 m_tuser == slcp_pkg::EV_FM_B) |->
      m_tdata[63:16] == '0 && (m_tuser != slcp_pkg::EV_PSG || m_tdata[7:0] == '0))
    else $error("chip write carries wait or seek data");

endmodule

bind sound_log_command_parser slcp_checker u_slcp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the sound-log command parser: directed and random byte streams.
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  reg_addr;
    logic [7:0]  data_val;
    logic [15:0] wait_len;
    logic [31:0] seek_pos;
    logic [31:0] total;
  } stream_event_t;

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [7:0]                       s_tdata;    // [7:0] stream_byte
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [95:0]                      m_tdata;    // [7:0] chip_register, [15:8] chip_value,
                                                // [31:16] wait_samples,
                                                // [63:32] seek_position,
                                                // [95:64] total_samples
  logic [2:0]                       m_tuser;    // [2:0] event_kind
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [slcp_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [31:0]                      cfg_data;

  // Decoder mirror and its register copies
  slcp_pkg::phase_t ph;
  logic [7:0]  cur_cmd;
  logic [2:0]  op_idx;
  logic [31:0] op_word;
  logic [31:0] skip_left;
  logic [31:0] wait_sum;
  logic [31:0] loop_reg;
  logic [31:0] start_reg;

  stream_event_t expected_events[$];

  int unsigned errors = 0;
  int unsigned bytes_sent = 0;
  int unsigned bytes_decoded = 0;
  int unsigned events_checked = 0;
  int unsigned waits_seen = 0;
  int unsigned seeks_seen = 0;
  int unsigned writes_seen = 0;
  int unsigned reg_writes = 0;

  bit          tx_steady = 1'b0;
  bit          rx_steady = 1'b0;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned rx_stall = 0;

  sound_log_command_parser dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  initial begin
    #40_000_000;
    $display("** sound_log_command_parser: FAILED **");
    $display("%0t: timeout with %0d results outstanding", $time, expected_events.size());
    $finish;
  end

  function automatic int unsigned gap_length(input bit steady);
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned operand_bytes(input logic [7:0] c);
    case (c)
      slcp_pkg::CMD_IGNORE1, slcp_pkg::CMD_PSG_ALT, slcp_pkg::CMD_PSG: return 1;
      slcp_pkg::CMD_IGNORE2A, slcp_pkg::CMD_IGNORE2B, slcp_pkg::CMD_IGNORE2C,
      slcp_pkg::CMD_FM_A, slcp_pkg::CMD_FM_B, slcp_pkg::CMD_WAIT_WORD: return 2;
      slcp_pkg::CMD_IGNORE4: return 4;
      slcp_pkg::CMD_DATA_BLOCK: return 6;
      default: return 0;
    endcase
  endfunction

  function automatic void push_event(input logic [2:0] kind, input logic [7:0] ra,
                                     input logic [7:0] dv, input logic [15:0] wl,
                                     input logic [31:0] sp);
    expected_events.push_back('{kind, ra, dv, wl, sp, wait_sum});
  endfunction

  function automatic void add_wait(input logic [15:0] wl);
    wait_sum = wait_sum + 32'(wl);
    push_event(slcp_pkg::EV_WAIT, 8'h00, 8'h00, wl, 32'h0);
  endfunction

  // Advance the decoder mirror by one accepted stream byte.
  function automatic void decode_stream_byte(input logic [7:0] b);
    logic [7:0]  first;
    logic [31:0] size;
    first = op_word[31:24];
    if (ph == slcp_pkg::PH_SKIP) begin
      skip_left = skip_left - 32'd1;
      if (skip_left == 32'd0) ph = slcp_pkg::PH_COMMAND;
    end else if (ph == slcp_pkg::PH_OPERAND) begin
      if (int'(op_idx) + 1 >= operand_bytes(cur_cmd)) begin
        ph = slcp_pkg::PH_COMMAND;
        op_idx = 3'd0;
        case (cur_cmd)
          slcp_pkg::CMD_PSG, slcp_pkg::CMD_PSG_ALT:
            push_event(slcp_pkg::EV_PSG, 8'h00, b, 16'h0, 32'h0);
          slcp_pkg::CMD_FM_A: push_event(slcp_pkg::EV_FM_A, first, b, 16'h0, 32'h0);
          slcp_pkg::CMD_FM_B: push_event(slcp_pkg::EV_FM_B, first, b, 16'h0, 32'h0);
          slcp_pkg::CMD_WAIT_WORD: add_wait({b, first});
          slcp_pkg::CMD_DATA_BLOCK: begin
            size = {b, op_word[31:8]};
            if (size != 32'd0) begin
              skip_left = size;
              ph = slcp_pkg::PH_SKIP;
            end
          end
          default: ;
        endcase
      end else begin
        op_word = {b, op_word[31:8]};
        op_idx = op_idx + 3'd1;
      end
    end else if (operand_bytes(b) != 0) begin
      cur_cmd = b;
      op_idx = 3'd0;
      op_word = 32'h0;
      ph = slcp_pkg::PH_OPERAND;
    end else if (b == slcp_pkg::CMD_WAIT_NTSC) begin
      add_wait(slcp_pkg::WAIT_NTSC);
    end else if (b == slcp_pkg::CMD_WAIT_PAL) begin
      add_wait(slcp_pkg::WAIT_PAL);
    end else if (b[7:4] == slcp_pkg::CMD_WAIT_SHORT_HI) begin
      add_wait(16'(b[3:0]) + 16'd1);
    end else if (b[7:4] == slcp_pkg::CMD_WAIT_NIB_HI) begin
      add_wait(16'(b[3:0]));
    end else if (b == slcp_pkg::CMD_END) begin
      push_event(slcp_pkg::EV_SEEK, 8'h00, 8'h00, 16'h0,
                 (loop_reg == 32'd0) ? start_reg : slcp_pkg::LOOP_BASE + loop_reg);
    end else begin
      push_event(slcp_pkg::EV_SEEK, 8'h00, 8'h00, 16'h0, start_reg);
    end
  endfunction

  // Offer one byte; a data block may only start where the caller asks for it,
  // so stray block commands never swallow a huge random size.
  task automatic send_byte(input logic [7:0] b, input bit block_start = 1'b0);
    int unsigned gap;
    logic [7:0]  item;
    item = b;
    if (ph == slcp_pkg::PH_COMMAND && item == slcp_pkg::CMD_DATA_BLOCK && !block_start)
      item = slcp_pkg::CMD_END;
    gap = gap_length(tx_steady);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= item;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    bytes_sent++;
    if (ph != slcp_pkg::PH_SKIP) bytes_decoded++;
    decode_stream_byte(item);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk);
    // a byte with no result may still be in the pipeline
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [slcp_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == slcp_pkg::CFG_LOOP_OFFSET) loop_reg = val;
    else start_reg = val;
    reg_writes++;
  endtask

  task automatic set_regs(input logic [31:0] loop_val, input logic [31:0] start_val);
    drain_results();
    write_reg(slcp_pkg::CFG_LOOP_OFFSET, loop_val);
    write_reg(slcp_pkg::CFG_STREAM_ORIGIN, start_val);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_chip_writes();
    send_byte(slcp_pkg::CMD_PSG);     send_byte(8'hFF);
    send_byte(slcp_pkg::CMD_PSG_ALT); send_byte(8'h00);
    send_byte(slcp_pkg::CMD_FM_A);    send_byte(8'h00); send_byte(8'hFF);
    send_byte(slcp_pkg::CMD_FM_B);    send_byte(8'hFF); send_byte(8'h00);
  endtask

  task automatic test_waits();
    // zero waits still give a result
    send_byte(slcp_pkg::CMD_WAIT_WORD); send_byte(8'h00); send_byte(8'h00);
    send_byte(slcp_pkg::CMD_WAIT_WORD); send_byte(8'hFF); send_byte(8'hFF);
    send_byte(slcp_pkg::CMD_WAIT_NTSC);
    send_byte(slcp_pkg::CMD_WAIT_PAL);
    send_byte({slcp_pkg::CMD_WAIT_SHORT_HI, 4'h0});
    send_byte({slcp_pkg::CMD_WAIT_SHORT_HI, 4'hF});
    send_byte({slcp_pkg::CMD_WAIT_NIB_HI, 4'h0});
    send_byte({slcp_pkg::CMD_WAIT_NIB_HI, 4'hF});
  endtask

  task automatic test_ignored_and_blocks();
    send_byte(slcp_pkg::CMD_IGNORE1); send_byte(8'hAA);
    send_byte(slcp_pkg::CMD_IGNORE4);
    send_byte(8'h11); send_byte(8'h22); send_byte(8'h33); send_byte(8'h44);
    // empty block goes straight back to command decoding
    send_byte(slcp_pkg::CMD_DATA_BLOCK, 1'b1);
    repeat (6) send_byte(8'h00);
    send_byte({slcp_pkg::CMD_WAIT_NIB_HI, 4'h5});
  endtask

  task automatic test_seeks();
    send_byte(slcp_pkg::CMD_END);
    send_byte(8'h00);
    send_byte(8'hFF);
    set_regs(32'h0, 32'h0);
    send_byte(slcp_pkg::CMD_END);
    send_byte(8'h00);
    set_regs(32'hFFFF_FFE3, 32'hFFFF_FFFF);
    send_byte(slcp_pkg::CMD_END);
    send_byte(8'hFE);
    set_regs(32'h1, 32'd64);
    send_byte(slcp_pkg::CMD_END);
  endtask

  // Hold the result side while short waits stream in back to back.
  task automatic test_backpressure();
    drain_results();
    tx_steady = 1'b1;
    hold_req = 1'b1;
    repeat (40) send_byte({slcp_pkg::CMD_WAIT_SHORT_HI, 4'($urandom_range(0, 15))});
    tx_steady = 1'b0;
    drain_results();
  endtask

  task automatic send_random_command();
    int unsigned pick;
    int unsigned len;
    logic [7:0]  c;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      send_byte($urandom_range(0, 1) ? slcp_pkg::CMD_PSG : slcp_pkg::CMD_PSG_ALT);
      send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 30) begin
      send_byte($urandom_range(0, 1) ? slcp_pkg::CMD_FM_A : slcp_pkg::CMD_FM_B);
      send_byte(8'($urandom_range(0, 255)));
      send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 38) begin
      send_byte(slcp_pkg::CMD_WAIT_WORD);
      send_byte(8'($urandom_range(0, 255)));
      send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 44) begin
      send_byte($urandom_range(0, 1) ? slcp_pkg::CMD_WAIT_NTSC : slcp_pkg::CMD_WAIT_PAL);
    end else if (pick < 58) begin
      send_byte({$urandom_range(0, 1) ? slcp_pkg::CMD_WAIT_SHORT_HI : slcp_pkg::CMD_WAIT_NIB_HI,
                 4'($urandom_range(0, 15))});
    end else if (pick < 70) begin
      case ($urandom_range(0, 4))
        0: c = slcp_pkg::CMD_IGNORE1;
        1: c = slcp_pkg::CMD_IGNORE2A;
        2: c = slcp_pkg::CMD_IGNORE2B;
        3: c = slcp_pkg::CMD_IGNORE2C;
        default: c = slcp_pkg::CMD_IGNORE4;
      endcase
      send_byte(c);
      repeat (operand_bytes(c)) send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 78) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 40) : $urandom_range(0, 6);
      send_byte(slcp_pkg::CMD_DATA_BLOCK, 1'b1);
      send_byte(8'($urandom_range(0, 255)));
      send_byte(8'($urandom_range(0, 255)));
      send_byte(8'(len));
      repeat (3) send_byte(8'h00);
      repeat (len) send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 81) begin
      send_byte(slcp_pkg::CMD_END);
    end else if (pick < 84) begin
      do c = 8'($urandom_range(0, 255));
      while (operand_bytes(c) != 0 || c == slcp_pkg::CMD_WAIT_NTSC ||
             c == slcp_pkg::CMD_WAIT_PAL || c == slcp_pkg::CMD_END ||
             c[7:4] == slcp_pkg::CMD_WAIT_SHORT_HI || c[7:4] == slcp_pkg::CMD_WAIT_NIB_HI);
      send_byte(c);
    end else begin
      // noise: cuts sequences short and shifts operand alignment
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_stream(input int unsigned count);
    int unsigned target;
    int unsigned segment_end;
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      set_regs(($urandom_range(0, 3) == 0) ? 32'h0 : $urandom_range(1, 32'hFFFF_FFE3),
               $urandom());
      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      segment_end = bytes_sent + 250;
      while (bytes_sent < segment_end && bytes_sent < target) send_random_command();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    ph = slcp_pkg::PH_COMMAND;
    cur_cmd = 8'h00;
    op_idx = 3'd0;
    op_word = 32'h0;
    skip_left = 32'h0;
    wait_sum = 32'h0;
    loop_reg = 32'h0;
    start_reg = slcp_pkg::STREAM_ORIGIN_INIT;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= 8'h00;
    cfg_valid <= 1'b0;
    cfg_index <= slcp_pkg::CFG_LOOP_OFFSET;
    cfg_data <= 32'h0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_chip_writes();
    test_waits();
    test_ignored_and_blocks();
    test_seeks();
    test_backpressure();
    test_random_stream(1460);
    drain_results();

    $display("Covered %0d stream bytes (%0d decoded) under %0d register writes;",
             bytes_sent, bytes_decoded, reg_writes);
    $display("checked %0d events: %0d chip writes, %0d waits, %0d seeks, total 0x%08h.",
             events_checked, writes_seen, waits_seen, seeks_seen, wait_sum);
    if (errors == 0) begin
      $display("** sound_log_command_parser: PASSED **");
    end else begin
      $display("** sound_log_command_parser: FAILED **");
    end
    $finish;
  end

  // Result side readiness: random stalls, steady stretches, one long hold.
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = 80;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (!rx_steady && $urandom_range(0, 2) == 0) rx_stall = gap_length(1'b0);
    end
  end

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    stream_event_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_events.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual kind %0d data 0x%0h",
                 $time, m_tuser, m_tdata);
      end else begin
        want = expected_events.pop_front();
        compare_field("event_kind", 32'(want.kind), 32'(m_tuser));
        compare_field("chip_register", 32'(want.reg_addr), 32'(m_tdata[7:0]));
        compare_field("chip_value", 32'(want.data_val), 32'(m_tdata[15:8]));
        compare_field("wait_samples", 32'(want.wait_len), 32'(m_tdata[31:16]));
        compare_field("seek_position", want.seek_pos, m_tdata[63:32]);
        compare_field("total_samples", want.total, m_tdata[95:64]);
        events_checked++;
        if (want.kind == slcp_pkg::EV_WAIT) waits_seen++;
        else if (want.kind == slcp_pkg::EV_SEEK) seeks_seen++;
        else writes_seen++;
      end
    end
  end

endmodule

// ===== sound_log_command_parser.f =====
rtl/slcp_pkg.sv
rtl/slcp_front.sv
rtl/slcp_queue.sv
rtl/slcp_back.sv
rtl/sound_log_command_parser.sv
rtl/slcp_checker.sv
tb/sv/testbench.sv
